@@ rtl/core/led_keyframe_fader_unit_assert.svh @@
// Assertion macros for the keyframe fader.
`ifndef LED_KEYFRAME_FADER_UNIT_ASSERT_SVH
`define LED_KEYFRAME_FADER_UNIT_ASSERT_SVH
`ifndef SYNTHESIS
`define LKF_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("keyframe fader assertion failed");
`define LKF_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("keyframe fader assertion failed");
`else
`define LKF_ASSERT_SAME(label, ante, cons)
`define LKF_ASSERT_NEXT(label, ante, cons)
`endif
`endif

@@ rtl/core/lkf_pkg.sv @@
package lkf_pkg;

    localparam int CHANNELS   = 10;
    localparam int STEP_DEPTH = 32;
    localparam int CH_W       = $clog2(CHANNELS);
    localparam int ADDR_W     = $clog2(STEP_DEPTH);
    localparam int DUTY_W     = 15;
    localparam int PROD_W     = 2 * DUTY_W;
    localparam logic [15:0] DIV10_MUL = 16'd52429;

    typedef enum logic [1:0] {
        FUNC_WRITE = 2'd0,
        FUNC_START = 2'd1,
        FUNC_TICK  = 2'd2,
        FUNC_NONE  = 2'd3
    } t_func;

    localparam logic [1:0] KIND_CONTINUE = 2'd0;
    localparam logic [1:0] KIND_REPEAT   = 2'd1;
    localparam logic [1:0] KIND_END      = 2'd2;
    localparam logic [1:0] KIND_UNUSED   = 2'd3;

    typedef struct packed {
        logic        has_next;
        logic [4:0]  next_addr;
        logic [7:0]  repeat_total;
        logic [1:0]  step_kind;
        logic        curve_kind;
        logic [14:0] step_duration;
        logic [14:0] target_duty;
    } t_step;

    function automatic logic [11:0] div10(input logic [14:0] d);
        logic [30:0] p;
        p = 31'(d) * 31'(DIV10_MUL);
        return p[30:19];
    endfunction

endpackage

@@ rtl/core/lkf_muldiv.sv @@
module lkf_muldiv (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [14:0] i_a,
    input  logic [14:0] i_b,
    input  logic [14:0] i_d,
    output logic        o_done,
    output logic [14:0] o_q
);

    typedef enum logic [3:0] {
        MD_IDLE = 4'b0001,
        MD_MUL  = 4'b0010,
        MD_DIV  = 4'b0100,
        MD_DONE = 4'b1000
    } t_md_state;

    t_md_state r_state, n_state;
    logic [4:0]  r_cnt;
    logic [lkf_pkg::PROD_W-1:0] r_acc;
    logic [lkf_pkg::PROD_W-1:0] r_mcand;
    logic [14:0] r_mplier;
    logic [14:0] r_rem;
    logic [14:0] r_d;
    logic [15:0] w_trial;
    logic        w_ge;
    logic        w_load;

    assign w_load  = i_start && (r_state == MD_IDLE || r_state == MD_DONE);
    assign w_trial = {r_rem, r_acc[lkf_pkg::PROD_W-1]};
    assign w_ge    = w_trial >= {1'b0, r_d};
    assign o_done  = (r_state == MD_DONE);
    assign o_q     = r_acc[14:0];

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            MD_IDLE: begin
                if (w_load) n_state = MD_MUL;
            end
            MD_MUL: begin
                if (r_cnt == 5'd0) n_state = MD_DIV;
            end
            MD_DIV: begin
                if (r_cnt == 5'd0) n_state = MD_DONE;
            end
            MD_DONE: begin
                n_state = w_load ? MD_MUL : MD_IDLE;
            end
            default: n_state = MD_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= MD_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_acc    <= '0;
            r_mcand  <= lkf_pkg::PROD_W'(i_a);
            r_mplier <= i_b;
            r_d      <= i_d;
            r_cnt    <= 5'd14;
        end else if (r_state == MD_MUL) begin
            if (r_mplier[0]) r_acc <= r_acc + r_mcand;
            r_mcand  <= {r_mcand[lkf_pkg::PROD_W-2:0], 1'b0};
            r_mplier <= {1'b0, r_mplier[14:1]};
            r_rem    <= '0;
            r_cnt    <= (r_cnt == 5'd0) ? 5'(lkf_pkg::PROD_W - 1) : r_cnt - 5'd1;
        end else if (r_state == MD_DIV) begin
            r_rem <= w_ge ? 15'(w_trial - {1'b0, r_d}) : w_trial[14:0];
            r_acc <= {r_acc[lkf_pkg::PROD_W-2:0], w_ge};
            r_cnt <= r_cnt - 5'd1;
        end
    end

endmodule

@@ rtl/core/led_keyframe_fader_unit.sv @@
// Keyframe LED fader for ten channels. A write or a start transfer is taken when idle.
// A tick walks the channels in order and sends one result per channel, channel 0 first,
// tlast on the final one. An animating channel is set by passes through one shared
// shift-add multiplier and restoring divider, each pass a multiply phase, a divide phase
// and a done state: a linear ramp needs two passes, a static jump or a zero-length step
// one pass, and a finished step adds the ADV1 and ADV2 states to read and apply the next
// entry. A tick is held up in every cycle in which the receiver holds off a result.
// The step memory (32 entries) has one write and one registered read port and is
// undefined until written; no channel may reach an unwritten step.
`include "led_keyframe_fader_unit_assert.svh"
module led_keyframe_fader_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    // now_ms, channel_sel, step_addr, target_duty, step_duration, curve_kind,
    // step_kind, repeat_total, next_addr, has_next
    input  logic [87:0] i_s_tdata,
    // func
    input  logic [1:0]  i_s_tuser,
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    // out_channel, duty_now, shown_level, zero pad
    output logic [31:0] o_m_tdata,
    // is_active
    output logic        o_m_tuser,
    output logic        o_m_tlast,
    input  logic        i_cfg_we,
    input  logic [14:0] i_cfg_wdata
);

    localparam int CH  = lkf_pkg::CHANNELS;
    localparam int AW  = lkf_pkg::ADDR_W;
    localparam int CW  = lkf_pkg::CH_W;

    typedef enum logic [7:0] {
        ST_IDLE = 8'b0000_0001,
        ST_RD   = 8'b0000_0010,
        ST_EVAL = 8'b0000_0100,
        ST_FRAC = 8'b0000_1000,
        ST_QUO  = 8'b0001_0000,
        ST_ADV1 = 8'b0010_0000,
        ST_ADV2 = 8'b0100_0000,
        ST_OUT  = 8'b1000_0000
    } t_state;

    t_state r_state, n_state;

    lkf_pkg::t_step r_mem [lkf_pkg::STEP_DEPTH];
    lkf_pkg::t_step r_mem_q;

    logic [AW-1:0] r_first [CH];
    logic [AW-1:0] r_cur   [CH];
    logic [31:0]   r_start [CH];
    logic          r_rep   [CH];
    logic [7:0]    r_left  [CH];
    logic          r_act   [CH];
    logic [14:0]   r_from  [CH];
    logic [14:0]   r_duty  [CH];

    logic [CW-1:0] r_ch;
    logic [31:0]   r_now;
    logic [14:0]   r_scale;
    logic          r_ovalid;
    logic [31:0]   r_o_data;
    logic          r_o_user;
    logic          r_o_last;

    logic           w_acc;
    logic [1:0]     w_func;
    logic [3:0]     w_sel;
    logic [AW-1:0]  w_addr;
    lkf_pkg::t_step w_kf;
    logic [AW-1:0]  w_rd_addr;
    logic [14:0]    w_scale;
    logic [31:0]    w_elapsed;
    logic           w_fin;
    logic [14:0]    w_passed;
    logic           w_up;
    logic [14:0]    w_delta;
    logic           w_linear;
    logic           w_md_start;
    logic [14:0]    w_md_a;
    logic [14:0]    w_md_b;
    logic [14:0]    w_md_d;
    logic           w_md_done;
    logic [14:0]    w_md_q;
    logic [14:0]    w_new_duty;
    logic           w_out_load;
    logic           w_last_ch;

    assign w_acc  = i_s_tvalid && o_s_tready;
    assign w_func = i_s_tuser;
    assign w_sel  = i_s_tdata[35:32];
    assign w_addr = AW'(i_s_tdata[40:36]);
    assign w_kf   = {i_s_tdata[87], i_s_tdata[86:82], i_s_tdata[81:74], i_s_tdata[73:72],
                     i_s_tdata[71], i_s_tdata[70:56], i_s_tdata[55:41]};

    assign o_s_tready = (r_state == ST_IDLE);
    assign o_m_tvalid = r_ovalid;
    assign o_m_tdata  = r_o_data;
    assign o_m_tuser  = r_o_user;
    assign o_m_tlast  = r_o_last;

    assign w_rd_addr = (r_state == ST_ADV1) ? r_cur[r_ch] + AW'(1) : r_cur[r_ch];
    assign w_scale   = (r_scale == 15'd0) ? 15'd1 : r_scale;
    assign w_elapsed = r_now - r_start[r_ch];
    assign w_fin     = w_elapsed >= {17'd0, r_mem_q.step_duration};
    assign w_passed  = w_fin ? r_mem_q.step_duration : w_elapsed[14:0];
    assign w_up      = r_mem_q.target_duty > r_from[r_ch];
    assign w_delta   = w_up ? r_mem_q.target_duty - r_from[r_ch]
                            : r_from[r_ch] - r_mem_q.target_duty;
    assign w_linear  = !r_mem_q.curve_kind && (r_mem_q.step_duration != 15'd0);
    assign w_new_duty = w_up ? r_from[r_ch] + w_md_q : r_from[r_ch] - w_md_q;
    assign w_out_load = (r_state == ST_OUT) && (!r_ovalid || i_m_tready);
    assign w_last_ch  = (r_ch == CW'(CH - 1));

    always_comb begin
        w_md_start = 1'b0;
        w_md_a     = w_scale;
        w_md_b     = w_delta;
        w_md_d     = w_scale;
        if (r_state == ST_EVAL && r_act[r_ch]) begin
            w_md_start = 1'b1;
            if (w_linear) begin
                w_md_b = w_passed;
                w_md_d = r_mem_q.step_duration;
            end else if (!r_mem_q.curve_kind) begin
                w_md_a = 15'd0;
            end
        end else if (r_state == ST_FRAC && w_md_done) begin
            w_md_start = 1'b1;
            w_md_a     = w_md_q;
        end
    end

    lkf_muldiv u_muldiv (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_md_start),
        .i_a     (w_md_a),
        .i_b     (w_md_b),
        .i_d     (w_md_d),
        .o_done  (w_md_done),
        .o_q     (w_md_q)
    );

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (w_acc && w_func == lkf_pkg::FUNC_TICK) n_state = ST_RD;
            end
            ST_RD: n_state = ST_EVAL;
            ST_EVAL: begin
                if (!r_act[r_ch]) n_state = ST_OUT;
                else if (w_linear) n_state = ST_FRAC;
                else n_state = ST_QUO;
            end
            ST_FRAC: begin
                if (w_md_done) n_state = ST_QUO;
            end
            ST_QUO: begin
                if (w_md_done) n_state = w_fin ? ST_ADV1 : ST_OUT;
            end
            ST_ADV1: n_state = ST_ADV2;
            ST_ADV2: n_state = ST_OUT;
            ST_OUT: begin
                if (w_out_load) n_state = w_last_ch ? ST_IDLE : ST_RD;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_acc && w_func == lkf_pkg::FUNC_WRITE) r_mem[w_addr] <= w_kf;
        r_mem_q <= r_mem[w_rd_addr];
        if (w_acc) r_now <= i_s_tdata[31:0];
        if (w_out_load) begin
            r_o_data <= {1'b0, lkf_pkg::div10(r_duty[r_ch]), r_duty[r_ch], 4'(r_ch)};
            r_o_user <= r_act[r_ch];
            r_o_last <= w_last_ch;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_ch     <= '0;
            r_scale  <= 15'd100;
            r_ovalid <= 1'b0;
            for (int c = 0; c < CH; c++) begin
                r_first[c] <= '0;
                r_cur[c]   <= '0;
                r_start[c] <= '0;
                r_rep[c]   <= 1'b0;
                r_left[c]  <= '0;
                r_act[c]   <= 1'b0;
                r_from[c]  <= '0;
                r_duty[c]  <= '0;
            end
        end else begin
            r_state <= n_state;
            if (i_cfg_we) r_scale <= i_cfg_wdata;
            if (w_out_load) begin
                r_ovalid <= 1'b1;
                r_ch     <= w_last_ch ? '0 : r_ch + CW'(1);
            end else if (r_ovalid && i_m_tready) begin
                r_ovalid <= 1'b0;
            end
            if (w_acc && w_func == lkf_pkg::FUNC_START && 32'(w_sel) < CH) begin
                r_first[CW'(w_sel)] <= w_addr;
                r_cur[CW'(w_sel)]   <= w_addr;
                r_start[CW'(w_sel)] <= i_s_tdata[31:0];
                r_rep[CW'(w_sel)]   <= 1'b0;
                r_left[CW'(w_sel)]  <= '0;
                r_act[CW'(w_sel)]   <= 1'b1;
                r_from[CW'(w_sel)]  <= r_duty[CW'(w_sel)];
            end
            if (r_state == ST_QUO && w_md_done) r_duty[r_ch] <= w_new_duty;
            if (r_state == ST_ADV1) begin
                r_start[r_ch] <= r_start[r_ch] + {17'd0, r_mem_q.step_duration};
                r_cur[r_ch]   <= r_cur[r_ch] + AW'(1);
                r_from[r_ch]  <= r_duty[r_ch];
            end
            if (r_state == ST_ADV2) begin
                if (r_mem_q.step_kind == lkf_pkg::KIND_REPEAT) begin
                    if (!r_rep[r_ch]) begin
                        r_rep[r_ch]  <= 1'b1;
                        r_left[r_ch] <= r_mem_q.repeat_total;
                        r_cur[r_ch]  <= r_first[r_ch];
                    end else if (r_mem_q.repeat_total == 8'd0) begin
                        r_cur[r_ch] <= r_first[r_ch];
                    end else if (r_left[r_ch] > 8'd1) begin
                        r_cur[r_ch]  <= r_first[r_ch];
                        r_left[r_ch] <= r_left[r_ch] - 8'd1;
                    end else begin
                        r_rep[r_ch] <= 1'b0;
                        r_cur[r_ch] <= r_cur[r_ch] + AW'(1);
                    end
                end else if (r_mem_q.step_kind == lkf_pkg::KIND_END) begin
                    if (r_mem_q.has_next) begin
                        r_first[r_ch] <= AW'(r_mem_q.next_addr);
                        r_cur[r_ch]   <= AW'(r_mem_q.next_addr);
                    end else begin
                        r_act[r_ch]  <= 1'b0;
                        r_rep[r_ch]  <= 1'b0;
                        r_left[r_ch] <= '0;
                    end
                end
            end
        end
    end

    `LKF_ASSERT_SAME(a_ch_range, 1'b1, 32'(r_ch) < CH)
    `LKF_ASSERT_SAME(a_md_wait, w_md_done, r_state == ST_FRAC || r_state == ST_QUO)
    `LKF_ASSERT_NEXT(a_tick_busy, w_acc && w_func == lkf_pkg::FUNC_TICK, !o_s_tready)
    `LKF_ASSERT_SAME(a_last_ch, o_m_tvalid && o_m_tlast, o_m_tdata[3:0] == 4'(CH - 1))

endmodule

@@ tb/sv/tb_led_keyframe_fader_unit.sv @@
module tb_led_keyframe_fader_unit;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT = 2000000;
    localparam int SETTLE = 50;

    typedef struct {
        logic [3:0]  chan;
        logic [14:0] duty;
        logic [11:0] level;
        logic        active;
        logic        last;
    } t_duty_exp;

    typedef struct {
        lkf_pkg::t_func func;
        logic [31:0] now;
        logic [3:0]  chan;
        logic [4:0]  addr;
        logic [14:0] target;
        logic [14:0] dur;
        logic        curve;
        logic [1:0]  kind;
        logic [7:0]  rep;
        logic [4:0]  nxt;
        logic        hn;
        int          fixed_duty;
    } t_row;

    logic        i_clk = 0;
    logic        i_rst_n = 0;
    logic        i_s_tvalid = 0;
    logic        o_s_tready;
    logic [87:0] i_s_tdata = '0;
    logic [1:0]  i_s_tuser = '0;
    logic        o_m_tvalid;
    logic        i_m_tready = 0;
    logic [31:0] o_m_tdata;
    logic        o_m_tuser;
    logic        o_m_tlast;
    logic        i_cfg_we = 0;
    logic [14:0] i_cfg_wdata = '0;

    led_keyframe_fader_unit u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .i_s_tuser   (i_s_tuser),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),
        .o_m_tuser   (o_m_tuser),
        .o_m_tlast   (o_m_tlast),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata)
    );

    always #2 i_clk = ~i_clk;

    // Predictor state.
    lkf_pkg::t_step keyframes [lkf_pkg::STEP_DEPTH];
    logic [4:0]  first_step [lkf_pkg::CHANNELS];
    logic [4:0]  cur_step [lkf_pkg::CHANNELS];
    logic [31:0] start_ms [lkf_pkg::CHANNELS];
    logic        repeating [lkf_pkg::CHANNELS];
    logic [7:0]  repeats_left [lkf_pkg::CHANNELS];
    logic        animating [lkf_pkg::CHANNELS];
    logic [14:0] origin_duty [lkf_pkg::CHANNELS];
    logic [14:0] held_duty [lkf_pkg::CHANNELS];
    logic [14:0] fade_scale = 15'd100;

    t_duty_exp duty_queue[$];
    int  errors = 0;
    int  cycles = 0;
    bit  quiet = 0;
    bit  hold_req = 0;
    int  hold_cnt = 0;
    int  gap_cnt = 0;
    logic [31:0] tnow = 0;

    function automatic logic [14:0] ramp_duty(int c, logic [31:0] now);
        lkf_pkg::t_step k;
        logic [31:0] sc, dur, passed, frac, from, to, d;
        k = keyframes[cur_step[c]];
        sc = (fade_scale == 0) ? 32'd1 : 32'(fade_scale);
        dur = 32'(k.step_duration);
        passed = now - start_ms[c];
        if (passed > dur) passed = dur;
        if (k.curve_kind) frac = sc;
        else frac = (dur != 0) ? (sc * passed) / dur : 32'd0;
        from = 32'(origin_duty[c]);
        to = 32'(k.target_duty);
        if (to > from) d = from + (frac * (to - from)) / sc;
        else d = from - (frac * (from - to)) / sc;
        return d[14:0];
    endfunction

    task automatic next_keyframe(int c);
        lkf_pkg::t_step k;
        k = keyframes[cur_step[c]];
        start_ms[c] += 32'(k.step_duration);
        cur_step[c] = cur_step[c] + 5'd1;
        k = keyframes[cur_step[c]];
        if (k.step_kind == lkf_pkg::KIND_REPEAT) begin
            if (!repeating[c]) begin
                repeating[c] = 1;
                repeats_left[c] = k.repeat_total;
                cur_step[c] = first_step[c];
            end else if (k.repeat_total == 0) begin
                cur_step[c] = first_step[c];
            end else if (repeats_left[c] > 1) begin
                cur_step[c] = first_step[c];
                repeats_left[c]--;
            end else begin
                repeating[c] = 0;
                cur_step[c] = cur_step[c] + 5'd1;
            end
        end else if (k.step_kind == lkf_pkg::KIND_END) begin
            if (k.has_next) begin
                first_step[c] = k.next_addr;
                cur_step[c] = k.next_addr;
            end else begin
                animating[c] = 0;
                repeating[c] = 0;
                repeats_left[c] = 0;
            end
        end
        origin_duty[c] = held_duty[c];
    endtask

    task automatic apply_item(logic [1:0] f, logic [87:0] d, int fixed_duty);
        logic [31:0] now;
        logic [3:0]  ch;
        logic        done;
        t_duty_exp   e;
        now = d[31:0];
        ch = d[35:32];
        if (f == lkf_pkg::FUNC_WRITE) begin
            keyframes[d[40:36]] = lkf_pkg::t_step'(d[87:41]);
        end else if (f == lkf_pkg::FUNC_START) begin
            if (ch < lkf_pkg::CHANNELS) begin
                first_step[ch] = d[40:36];
                cur_step[ch] = d[40:36];
                start_ms[ch] = now;
                repeating[ch] = 0;
                animating[ch] = 1;
                origin_duty[ch] = held_duty[ch];
                repeats_left[ch] = 0;
            end
        end else if (f == lkf_pkg::FUNC_TICK) begin
            for (int c = 0; c < lkf_pkg::CHANNELS; c++) begin
                if (animating[c]) begin
                    done = (now - start_ms[c]) >= 32'(keyframes[cur_step[c]].step_duration);
                    held_duty[c] = ramp_duty(c, now);
                    if (done) next_keyframe(c);
                end
                e.chan = 4'(c);
                e.duty = held_duty[c];
                e.level = 12'(held_duty[c] / 10);
                e.active = animating[c];
                e.last = (c == lkf_pkg::CHANNELS - 1);
                if (fixed_duty >= 0) begin
                    e.duty = 15'(fixed_duty);
                    e.level = 12'(fixed_duty / 10);
                    e.active = 0;
                end
                duty_queue.push_back(e);
            end
        end
    endtask

    task automatic send_item(logic [1:0] f, logic [87:0] d, int fixed_duty);
        i_s_tvalid <= 1;
        i_s_tuser <= f;
        i_s_tdata <= d;
        do @(posedge i_clk); while (!o_s_tready);
        apply_item(f, d, fixed_duty);
        if (!quiet && $urandom_range(0, 4) == 0) begin
            i_s_tvalid <= 0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
        end
    endtask

    function automatic logic [87:0] pack_item(logic [31:0] now, logic [3:0] ch,
                                              logic [4:0] addr, lkf_pkg::t_step k);
        return {k, addr, ch, now};
    endfunction

    function automatic lkf_pkg::t_step rand_keyframe();
        lkf_pkg::t_step k;
        int r;
        k.target_duty = 15'($urandom);
        r = $urandom_range(0, 19);
        k.step_duration = (r == 0) ? 15'd32767 : (r == 1) ? 15'($urandom) :
                          (r < 4) ? 15'd0 : 15'($urandom_range(1, 200));
        k.curve_kind = ($urandom_range(0, 9) == 0);
        r = $urandom_range(0, 19);
        k.step_kind = (r < 13) ? lkf_pkg::KIND_CONTINUE :
                      (r < 15) ? lkf_pkg::KIND_REPEAT :
                      (r < 19) ? lkf_pkg::KIND_END : lkf_pkg::KIND_UNUSED;
        r = $urandom_range(0, 9);
        k.repeat_total = (r == 0) ? 8'd255 : (r == 1) ? 8'($urandom) : 8'($urandom_range(0, 3));
        k.next_addr = 5'($urandom);
        k.has_next = ($urandom_range(0, 9) < 7);
        return k;
    endfunction

    task automatic set_scale(logic [14:0] v);
        i_s_tvalid <= 0;
        @(posedge i_clk);
        while (duty_queue.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
        i_cfg_we <= 1;
        i_cfg_wdata <= v;
        @(posedge i_clk);
        i_cfg_we <= 0;
        fade_scale = v;
    endtask

    task automatic random_item();
        int r;
        logic [31:0] now;
        r = $urandom_range(0, 99);
        tnow += $urandom_range(0, 150);
        if ($urandom_range(0, 29) == 0) tnow = $urandom;
        now = tnow;
        if (r < 40) begin
            send_item(lkf_pkg::FUNC_TICK, pack_item(now, 4'($urandom), 5'($urandom),
                      lkf_pkg::t_step'(0)), -1);
        end else if (r < 62) begin
            if ($urandom_range(0, 9) == 0) now = tnow + $urandom_range(1, 300);
            send_item(lkf_pkg::FUNC_START,
                      pack_item(now, 4'($urandom_range(0, lkf_pkg::CHANNELS - 1)),
                      5'($urandom), rand_keyframe()), -1);
        end else if (r < 92) begin
            send_item(lkf_pkg::FUNC_WRITE, pack_item($urandom, 4'($urandom), 5'($urandom),
                      rand_keyframe()), -1);
        end else if (r < 96) begin
            send_item(lkf_pkg::FUNC_NONE, 88'({$urandom, $urandom, $urandom}), -1);
        end else begin
            send_item(lkf_pkg::FUNC_START,
                      pack_item(now, 4'($urandom_range(lkf_pkg::CHANNELS, 15)),
                      5'($urandom), rand_keyframe()), -1);
        end
    endtask

    t_row rows[] = '{
        '{lkf_pkg::FUNC_TICK,  32'd0,        4'd0,  5'd0,  15'd0,     15'd0,
          1'b0, lkf_pkg::KIND_CONTINUE, 8'd0,   5'd0,  1'b0, 0},
        '{lkf_pkg::FUNC_WRITE, 32'd0,        4'd0,  5'd0,  15'd32767, 15'd100,
          1'b0, lkf_pkg::KIND_CONTINUE, 8'd0,   5'd0,  1'b0, -1},
        '{lkf_pkg::FUNC_WRITE, 32'd0,        4'd0,  5'd1,  15'd0,     15'd0,
          1'b1, lkf_pkg::KIND_CONTINUE, 8'd0,   5'd0,  1'b0, -1},
        '{lkf_pkg::FUNC_WRITE, 32'd0,        4'd0,  5'd2,  15'd0,     15'd0,
          1'b0, lkf_pkg::KIND_REPEAT,   8'd2,   5'd0,  1'b0, -1},
        '{lkf_pkg::FUNC_WRITE, 32'd0,        4'd0,  5'd3,  15'd500,   15'd50,
          1'b0, lkf_pkg::KIND_UNUSED,   8'd255, 5'd31, 1'b1, -1},
        '{lkf_pkg::FUNC_WRITE, 32'd0,        4'd0,  5'd4,  15'd0,     15'd0,
          1'b0, lkf_pkg::KIND_END,      8'd0,   5'd31, 1'b1, -1},
        '{lkf_pkg::FUNC_WRITE, 32'd0,        4'd0,  5'd31, 15'd1234,  15'd32767,
          1'b0, lkf_pkg::KIND_CONTINUE, 8'd0,   5'd0,  1'b0, -1},
        '{lkf_pkg::FUNC_WRITE, 32'd0,        4'd0,  5'd6,  15'd0,     15'd0,
          1'b0, lkf_pkg::KIND_END,      8'd0,   5'd0,  1'b0, -1},
        '{lkf_pkg::FUNC_START, 32'd1000,     4'd0,  5'd0,  15'd0,     15'd0,
          1'b0, lkf_pkg::KIND_CONTINUE, 8'd0,   5'd0,  1'b0, -1},
        '{lkf_pkg::FUNC_START, 32'd1000,     4'd9,  5'd1,  15'd0,     15'd0,
          1'b0, lkf_pkg::KIND_CONTINUE, 8'd0,   5'd0,  1'b0, -1},
        '{lkf_pkg::FUNC_START, 32'd1000,     4'd15, 5'd5,  15'd0,     15'd0,
          1'b0, lkf_pkg::KIND_CONTINUE, 8'd0,   5'd0,  1'b0, -1},
        '{lkf_pkg::FUNC_TICK,  32'd1050,     4'd0,  5'd0,  15'd0,     15'd0,
          1'b0, lkf_pkg::KIND_CONTINUE, 8'd0,   5'd0,  1'b0, -1},
        '{lkf_pkg::FUNC_TICK,  32'd1100,     4'd0,  5'd0,  15'd0,     15'd0,
          1'b0, lkf_pkg::KIND_CONTINUE, 8'd0,   5'd0,  1'b0, -1},
        '{lkf_pkg::FUNC_NONE,  32'hFFFFFFFF, 4'd15, 5'd31, 15'd32767, 15'd32767,
          1'b1, lkf_pkg::KIND_UNUSED,   8'd255, 5'd31, 1'b1, -1},
        '{lkf_pkg::FUNC_TICK,  32'd1100,     4'd0,  5'd0,  15'd0,     15'd0,
          1'b0, lkf_pkg::KIND_CONTINUE, 8'd0,   5'd0,  1'b0, -1},
        '{lkf_pkg::FUNC_START, 32'hFFFFFF00, 4'd5,  5'd31, 15'd0,     15'd0,
          1'b0, lkf_pkg::KIND_CONTINUE, 8'd0,   5'd0,  1'b0, -1},
        '{lkf_pkg::FUNC_TICK,  32'h00000100, 4'd0,  5'd0,  15'd0,     15'd0,
          1'b0, lkf_pkg::KIND_CONTINUE, 8'd0,   5'd0,  1'b0, -1},
        '{lkf_pkg::FUNC_START, 32'd5000,     4'd3,  5'd3,  15'd0,     15'd0,
          1'b0, lkf_pkg::KIND_CONTINUE, 8'd0,   5'd0,  1'b0, -1},
        '{lkf_pkg::FUNC_START, 32'd1200,     4'd7,  5'd6,  15'd0,     15'd0,
          1'b0, lkf_pkg::KIND_CONTINUE, 8'd0,   5'd0,  1'b0, -1},
        '{lkf_pkg::FUNC_TICK,  32'd4000,     4'd0,  5'd0,  15'd0,     15'd0,
          1'b0, lkf_pkg::KIND_CONTINUE, 8'd0,   5'd0,  1'b0, -1},
        '{lkf_pkg::FUNC_TICK,  32'd5025,     4'd0,  5'd0,  15'd0,     15'd0,
          1'b0, lkf_pkg::KIND_CONTINUE, 8'd0,   5'd0,  1'b0, -1},
        '{lkf_pkg::FUNC_TICK,  32'd5100,     4'd0,  5'd0,  15'd0,     15'd0,
          1'b0, lkf_pkg::KIND_CONTINUE, 8'd0,   5'd0,  1'b0, -1},
        '{lkf_pkg::FUNC_TICK,  32'd5200,     4'd0,  5'd0,  15'd0,     15'd0,
          1'b0, lkf_pkg::KIND_CONTINUE, 8'd0,   5'd0,  1'b0, -1}
    };

    always @(posedge i_clk) begin
        if (hold_cnt > 0) begin
            hold_cnt--;
            i_m_tready <= 0;
        end else if (hold_req) begin
            hold_req = 0;
            hold_cnt = 3000;
            i_m_tready <= 0;
        end else if (gap_cnt > 0) begin
            gap_cnt--;
            i_m_tready <= 0;
        end else if (!quiet && $urandom_range(0, 7) == 0) begin
            gap_cnt = $urandom_range(0, 5);
            i_m_tready <= 0;
        end else begin
            i_m_tready <= 1;
        end
    end

    always @(posedge i_clk) begin
        t_duty_exp e;
        if (o_m_tvalid && i_m_tready) begin
            if (duty_queue.size() == 0) begin
                $error("unexpected result transfer: tdata %h", o_m_tdata);
                errors++;
            end else begin
                e = duty_queue.pop_front();
                if (o_m_tdata[3:0] !== e.chan) begin
                    $error("out_channel: expected %0d, got %0d", e.chan, o_m_tdata[3:0]);
                    errors++;
                end
                if (o_m_tdata[18:4] !== e.duty) begin
                    $error("duty_now: expected %0d, got %0d", e.duty, o_m_tdata[18:4]);
                    errors++;
                end
                if (o_m_tdata[30:19] !== e.level) begin
                    $error("shown_level: expected %0d, got %0d", e.level, o_m_tdata[30:19]);
                    errors++;
                end
                if (o_m_tuser !== e.active) begin
                    $error("is_active: expected %0d, got %0d", e.active, o_m_tuser);
                    errors++;
                end
                if (o_m_tlast !== e.last) begin
                    $error("last_of_tick: expected %0d, got %0d", e.last, o_m_tlast);
                    errors++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("** led_keyframe_fader_unit: FAILED **");
            $finish;
        end
    end

    initial begin
        logic [14:0] scales [4];
        t_row r;
        for (int c = 0; c < lkf_pkg::CHANNELS; c++) begin
            first_step[c] = 0;
            cur_step[c] = 0;
            start_ms[c] = 0;
            repeating[c] = 0;
            repeats_left[c] = 0;
            animating[c] = 0;
            origin_duty[c] = 0;
            held_duty[c] = 0;
        end
        for (int a = 0; a < lkf_pkg::STEP_DEPTH; a++) keyframes[a] = '0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);

        // Every step entry is written before any channel starts, so none is read unwritten.
        for (int a = 0; a < lkf_pkg::STEP_DEPTH; a++)
            send_item(lkf_pkg::FUNC_WRITE, pack_item(32'd0, 4'd0, 5'(a), rand_keyframe()), -1);

        foreach (rows[i]) begin
            r = rows[i];
            send_item(r.func, pack_item(r.now, r.chan, r.addr,
                      '{r.hn, r.nxt, r.rep, r.kind, r.curve, r.dur, r.target}), r.fixed_duty);
        end
        tnow = 32'd6000;

        scales[0] = 15'd1;
        scales[1] = 15'd32767;
        scales[2] = 15'd0;
        scales[3] = 15'($urandom_range(1, 32767));
        for (int p = 0; p < 4; p++) begin
            set_scale(scales[p]);
            if (p == 3) quiet = 1;
            for (int n = 0; n < 40; n++) begin
                if (p == 0 && n == 20) hold_req = 1;
                random_item();
            end
        end

        i_s_tvalid <= 0;
        @(posedge i_clk);
        while (duty_queue.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
        if (errors == 0) begin
            $display("** led_keyframe_fader_unit: PASSED **");
        end else begin
            $display("** led_keyframe_fader_unit: FAILED **");
        end
        $finish;
    end

endmodule

@@ led_keyframe_fader_unit.f @@
+incdir+rtl/core
rtl/core/lkf_pkg.sv
rtl/core/lkf_muldiv.sv
rtl/core/led_keyframe_fader_unit.sv
tb/sv/tb_led_keyframe_fader_unit.sv
